// ----- src/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, switched off while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- src/scs1_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package scs1_pkg;

    // Request codes carried on the op port.
    localparam logic [1:0] OP_BYTE       = 2'd0;
    localparam logic [1:0] OP_READ_CHAR  = 2'd1;
    localparam logic [1:0] OP_READ_EVENT = 2'd2;
    localparam logic [1:0] OP_CLEAR      = 2'd3;

    localparam int CODE_W  = 7;
    localparam int EVENT_W = 8;

    // Requests into the event queue for one beat.
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } t_evt_req;

    // Registered answer of the event queue, valid the cycle after a pop.
    typedef struct packed {
        logic              hit;
        logic [CODE_W-1:0] code;
        logic              pressed;
    } t_evt_rd;

    // Requests into the character ring for one beat.
    typedef struct packed {
        logic push;
        logic pop;
    } t_chr_req;

    // Registered answer of the character ring.
    typedef struct packed {
        logic              hit;
        logic [CODE_W-1:0] code;
    } t_chr_rd;

    // US layout set-1 make code to ASCII; zero means no character.
    function automatic logic [CODE_W-1:0] set1_to_ascii(input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] ch;
        begin
            case (code)
                7'd1:  ch = 7'd27;
                7'd2:  ch = 7'd49;
                7'd3:  ch = 7'd50;
                7'd4:  ch = 7'd51;
                7'd5:  ch = 7'd52;
                7'd6:  ch = 7'd53;
                7'd7:  ch = 7'd54;
                7'd8:  ch = 7'd55;
                7'd9:  ch = 7'd56;
                7'd10: ch = 7'd57;
                7'd11: ch = 7'd48;
                7'd12: ch = 7'd45;
                7'd13: ch = 7'd61;
                7'd14: ch = 7'd8;
                7'd15: ch = 7'd9;
                7'd16: ch = 7'd113;
                7'd17: ch = 7'd119;
                7'd18: ch = 7'd101;
                7'd19: ch = 7'd114;
                7'd20: ch = 7'd116;
                7'd21: ch = 7'd121;
                7'd22: ch = 7'd117;
                7'd23: ch = 7'd105;
                7'd24: ch = 7'd111;
                7'd25: ch = 7'd112;
                7'd26: ch = 7'd91;
                7'd27: ch = 7'd93;
                7'd28: ch = 7'd10;
                7'd30: ch = 7'd97;
                7'd31: ch = 7'd115;
                7'd32: ch = 7'd100;
                7'd33: ch = 7'd102;
                7'd34: ch = 7'd103;
                7'd35: ch = 7'd104;
                7'd36: ch = 7'd106;
                7'd37: ch = 7'd107;
                7'd38: ch = 7'd108;
                7'd39: ch = 7'd59;
                7'd40: ch = 7'd39;
                7'd41: ch = 7'd96;
                7'd43: ch = 7'd92;
                7'd44: ch = 7'd122;
                7'd45: ch = 7'd120;
                7'd46: ch = 7'd99;
                7'd47: ch = 7'd118;
                7'd48: ch = 7'd98;
                7'd49: ch = 7'd110;
                7'd50: ch = 7'd109;
                7'd51: ch = 7'd44;
                7'd52: ch = 7'd46;
                7'd53: ch = 7'd47;
                7'd55: ch = 7'd42;
                7'd57: ch = 7'd32;
                7'd71: ch = 7'd55;
                7'd72: ch = 7'd56;
                7'd73: ch = 7'd57;
                7'd74: ch = 7'd45;
                7'd75: ch = 7'd52;
                7'd76: ch = 7'd53;
                7'd77: ch = 7'd54;
                7'd78: ch = 7'd43;
                7'd79: ch = 7'd49;
                7'd80: ch = 7'd50;
                7'd81: ch = 7'd51;
                7'd82: ch = 7'd48;
                7'd83: ch = 7'd46;
                default: ch = '0;
            endcase
            return ch;
        end
    endfunction

endpackage

`default_nettype wire

// ----- src/scs1_event_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Event FIFO held in a synchronous RAM with a fill count.
module scs1_event_queue
    import scs1_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_evt_req           i_req,
    input  wire logic [EVENT_W-1:0] i_data,
    output t_evt_rd                 o_rd
);

    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);

    logic [EVENT_W-1:0] r_mem [DEPTH];
    logic [EVENT_W-1:0] r_rd_data;
    logic [AW-1:0]      r_wr_pos, n_wr_pos;
    logic [AW-1:0]      r_rd_pos, n_rd_pos;
    logic [FW-1:0]      r_fill, n_fill;
    logic               r_hit, n_hit;
    logic               do_push, do_pop;

    assign do_push = i_req.push && (r_fill != FW'(DEPTH));
    assign do_pop  = i_req.pop && (r_fill != '0);

    always_comb begin
        n_wr_pos = r_wr_pos;
        n_rd_pos = r_rd_pos;
        n_fill   = r_fill;
        n_hit    = do_pop;
        if (do_push) begin
            n_wr_pos = (r_wr_pos == AW'(DEPTH - 1)) ? '0 : r_wr_pos + 1'b1;
            n_fill   = r_fill + 1'b1;
        end
        if (do_pop) begin
            n_rd_pos = (r_rd_pos == AW'(DEPTH - 1)) ? '0 : r_rd_pos + 1'b1;
            n_fill   = r_fill - 1'b1;
        end
        if (i_req.clear) begin
            n_rd_pos = r_wr_pos;
            n_fill   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pos <= '0;
            r_rd_pos <= '0;
            r_fill   <= '0;
            r_hit    <= 1'b0;
        end else begin
            r_wr_pos <= n_wr_pos;
            r_rd_pos <= n_rd_pos;
            r_fill   <= n_fill;
            r_hit    <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_pos] <= i_data;
        end
        if (do_pop) begin
            r_rd_data <= r_mem[r_rd_pos];
        end
    end

    assign o_rd.hit     = r_hit;
    assign o_rd.code    = r_hit ? r_rd_data[CODE_W-1:0] : '0;
    assign o_rd.pressed = r_hit & r_rd_data[EVENT_W-1];

endmodule

`default_nettype wire

// ----- src/scs1_char_ring.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Character ring in a synchronous RAM; a full flag tells full from empty.
module scs1_char_ring
    import scs1_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_chr_req          i_req,
    input  wire logic [CODE_W-1:0] i_data,
    output t_chr_rd                o_rd
);

    localparam int AW = $clog2(DEPTH);

    logic [CODE_W-1:0] r_mem [DEPTH];
    logic [CODE_W-1:0] r_rd_data;
    logic [AW-1:0]     r_wr_pos, n_wr_pos;
    logic [AW-1:0]     r_rd_pos, n_rd_pos;
    logic              r_full, n_full;
    logic              r_hit, n_hit;
    logic              do_push, do_pop;

    assign do_push = i_req.push && !r_full;
    assign do_pop  = i_req.pop && (r_full || (r_wr_pos != r_rd_pos));

    always_comb begin
        n_wr_pos = r_wr_pos;
        n_rd_pos = r_rd_pos;
        n_full   = r_full;
        n_hit    = do_pop;
        if (do_push) begin
            n_wr_pos = (r_wr_pos == AW'(DEPTH - 1)) ? '0 : r_wr_pos + 1'b1;
            n_full   = (n_wr_pos == r_rd_pos);
        end
        if (do_pop) begin
            n_rd_pos = (r_rd_pos == AW'(DEPTH - 1)) ? '0 : r_rd_pos + 1'b1;
            n_full   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pos <= '0;
            r_rd_pos <= '0;
            r_full   <= 1'b0;
            r_hit    <= 1'b0;
        end else begin
            r_wr_pos <= n_wr_pos;
            r_rd_pos <= n_rd_pos;
            r_full   <= n_full;
            r_hit    <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_pos] <= i_data;
        end
        if (do_pop) begin
            r_rd_data <= r_mem[r_rd_pos];
        end
    end

    assign o_rd.hit  = r_hit;
    assign o_rd.code = r_hit ? r_rd_data : '0;

endmodule

`default_nettype wire

// ----- src/scancode_set1_keyboard_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Set-1 keyboard scancode queue with US ASCII translation.
// A request beat is taken when start is high and busy is low. i_op selects
// a scancode byte (i_scan_byte), a character read, an event read or a clear
// of the event queue. Every accepted beat gives exactly one result beat,
// marked by o_valid, in the next cycle. Fields that do not belong to the
// request are zero, so byte and clear beats return all zeros.
// A byte beat pushes its 7-bit code and press flag into the event RAM and,
// for a press with a table entry, the character into the character RAM.
// Read beats fetch the head entry from the RAM that port owns; the RAM read
// is registered, and the pointers move on the accept edge.
// A new request may be issued in every cycle while busy is low: one beat
// per clock is the sustained rate, with at most one access per RAM.
// Synchronous reset empties both queues and holds busy high for the first
// clock after reset is released. Results cannot be stalled; the receiver
// must take each o_valid beat in the cycle it appears.
module scancode_set1_keyboard_queue
    import scs1_pkg::*;
#(
    parameter int EVENT_DEPTH = 64,
    parameter int CHAR_DEPTH  = 256
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire logic [1:0]        i_op,
    input  wire logic [7:0]        i_scan_byte,
    output logic                   busy,
    output logic                   o_valid,
    output logic                   o_char_valid,
    output logic [CODE_W-1:0]      o_char_code,
    output logic                   o_event_valid,
    output logic [CODE_W-1:0]      o_event_code,
    output logic                   o_event_pressed
);

    logic              r_busy;
    logic              r_strobe;
    logic              accept;
    logic              pressed;
    logic [CODE_W-1:0] ascii;
    t_evt_req          evt_req;
    t_chr_req          chr_req;
    t_evt_rd           evt_rd;
    t_chr_rd           chr_rd;

    assign accept = start && !r_busy;

    // Bit 7 clear means a make code; prefix bytes fall out as releases.
    assign pressed = ~i_scan_byte[7];
    assign ascii   = set1_to_ascii(i_scan_byte[CODE_W-1:0]);

    assign evt_req.push  = accept && (i_op == OP_BYTE);
    assign evt_req.pop   = accept && (i_op == OP_READ_EVENT);
    assign evt_req.clear = accept && (i_op == OP_CLEAR);

    // The event queue may be full while the character ring still takes
    // the translated character, so the two pushes are independent.
    assign chr_req.push = accept && (i_op == OP_BYTE) && pressed && (ascii != '0);
    assign chr_req.pop  = accept && (i_op == OP_READ_CHAR);

    scs1_event_queue #(
        .DEPTH (EVENT_DEPTH)
    ) u_evt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (evt_req),
        .i_data  ({pressed, i_scan_byte[CODE_W-1:0]}),
        .o_rd    (evt_rd)
    );

    scs1_char_ring #(
        .DEPTH (CHAR_DEPTH)
    ) u_chr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (chr_req),
        .i_data  (ascii),
        .o_rd    (chr_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b1;
            r_strobe <= 1'b0;
        end else begin
            r_busy   <= 1'b0;
            r_strobe <= accept;
        end
    end

    assign busy            = r_busy;
    assign o_valid         = r_strobe;
    assign o_char_valid    = chr_rd.hit;
    assign o_char_code     = chr_rd.code;
    assign o_event_valid   = evt_rd.hit;
    assign o_event_code    = evt_rd.code;
    assign o_event_pressed = evt_rd.pressed;

endmodule

`default_nettype wire

// ----- src/scs1_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

// Port-level checks on the request and result beats.
module scs1_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic [1:0] i_op,
    input wire logic [7:0] i_scan_byte,
    input wire logic       busy,
    input wire logic       o_valid,
    input wire logic       o_char_valid,
    input wire logic [6:0] o_char_code,
    input wire logic       o_event_valid,
    input wire logic [6:0] o_event_code,
    input wire logic       o_event_pressed
);

    logic unused_in;
    assign unused_in = ^{i_op, i_scan_byte, o_event_code, o_event_pressed};

    `ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, start && !busy, o_valid)
    `ASSERT_IMPLY(a_no_stray_result, i_clk, i_rst_n, o_valid, $past(start && !busy))
    `ASSERT_IMPLY(a_hits_need_beat, i_clk, i_rst_n, !o_valid, !o_char_valid && !o_event_valid)
    `ASSERT_IMPLY(a_char_nonzero, i_clk, i_rst_n, o_char_valid, o_char_code != 7'd0)

endmodule

bind scancode_set1_keyboard_queue scs1_checker u_scs1_checker (.*);

`default_nettype wire
